@@ rtl/dmc_pkg.sv @@
// Package with the shared types, constants and helpers of the direct-mapped cache RAM.
package dmc_pkg;

  localparam int STORE_BYTES = 8192;
  localparam int STORE_WORDS = STORE_BYTES / 4;
  localparam int WORD_AW     = $clog2(STORE_WORDS);
  localparam int BYTE_AW     = $clog2(STORE_BYTES);
  localparam int PAGE_W      = 32 - BYTE_AW;

  localparam logic [31:0] DATA_WIN_BASE = 32'h0001_2000;
  localparam logic [31:0] CC_WIN_BASE   = 32'h0001_4000;
  localparam logic [7:0]  OUT_OF_WINDOW = 8'hFF;

  localparam int ENTRY_COUNT_DEF    = 2048;
  localparam int INDEX_SHIFT_DEF    = 2;
  localparam int TAG_SHIFT_DEF      = 13;
  localparam int COND_TAG_SHIFT_DEF = 8;
  localparam int VALID_BIT_DEF      = 0;

  typedef enum logic [2:0] {
    REQ_RD_DATA = 3'd0,
    REQ_WR_DATA = 3'd1,
    REQ_RD_CC   = 3'd2,
    REQ_WR_CC   = 3'd3,
    REQ_LOOKUP  = 3'd4,
    REQ_FILL    = 3'd5,
    REQ_INVAL   = 3'd6
  } req_type_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP,
    ST_INVAL
  } state_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [31:0] bus_address;
    logic [31:0] write_value;
  } in_beat_t;

  typedef struct packed {
    logic [7:0]  read_byte;
    logic        hit;
    logic [31:0] hit_word;
  } out_beat_t;

  typedef struct packed {
    logic               we;
    logic               re;
    logic [WORD_AW-1:0] addr;
    logic [31:0]        wdata;
  } ram_req_t;

  function automatic logic in_window(logic [31:0] addr, logic [31:0] base);
    return addr[31:BYTE_AW] == base[31:BYTE_AW];
  endfunction

  function automatic logic [7:0] get_lane(logic [31:0] w, logic [1:0] lane);
    logic [7:0] b;
    case (lane)
      2'd0:    b = w[31:24];
      2'd1:    b = w[23:16];
      2'd2:    b = w[15:8];
      default: b = w[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [31:0] put_lane(logic [31:0] w, logic [1:0] lane, logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (lane)
      2'd0:    r[31:24] = b;
      2'd1:    r[23:16] = b;
      2'd2:    r[15:8]  = b;
      default: r[7:0]   = b;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/dmc_ram.sv @@
// Generic single-port synchronous RAM with a registered read port.
module dmc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/dmc_ctrl.sv @@
// Sequencer and datapath: request decode, read-modify-write, clearing sweeps and result register.
module dmc_ctrl #(
  parameter int ENTRY_COUNT    = dmc_pkg::ENTRY_COUNT_DEF,
  parameter int INDEX_SHIFT    = dmc_pkg::INDEX_SHIFT_DEF,
  parameter int TAG_SHIFT      = dmc_pkg::TAG_SHIFT_DEF,
  parameter int COND_TAG_SHIFT = dmc_pkg::COND_TAG_SHIFT_DEF,
  parameter int VALID_BIT      = dmc_pkg::VALID_BIT_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  dmc_pkg::in_beat_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output dmc_pkg::out_beat_t  out_data,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  output dmc_pkg::ram_req_t   data_req,
  input  logic [31:0]         data_rdata,
  output dmc_pkg::ram_req_t   cond_req,
  input  logic [31:0]         cond_rdata
);

  localparam logic [31:0] IDX_MASK   = 32'(ENTRY_COUNT - 1);
  localparam logic [31:0] WORD_LIMIT = 32'(dmc_pkg::STORE_WORDS);
  localparam logic [dmc_pkg::WORD_AW-1:0] LAST_WORD = dmc_pkg::WORD_AW'(dmc_pkg::STORE_WORDS - 1);

  dmc_pkg::state_t               state_r, state_nxt;
  logic [dmc_pkg::WORD_AW-1:0]   cnt_r, cnt_nxt;
  dmc_pkg::in_beat_t             req_r, req_nxt;
  logic                          present_r, present_nxt;
  logic                          out_valid_r, out_valid_nxt;
  dmc_pkg::out_beat_t            out_data_r, out_data_nxt;

  logic                          accept;
  logic                          leave_resp;
  logic [31:0]                   in_idx, req_idx;
  logic                          in_ok, req_ok;
  logic [31:0]                   fill_cc;
  logic [dmc_pkg::WORD_AW-1:0]   in_waddr;
  dmc_pkg::out_beat_t            result;

  assign accept     = in_valid && !in_stall;
  assign leave_resp = (state_r == dmc_pkg::ST_RESP) && (!out_valid_r || !out_stall);

  assign in_idx   = (in_data.bus_address >> INDEX_SHIFT) & IDX_MASK;
  assign in_ok    = in_idx < WORD_LIMIT;
  assign req_idx  = (req_r.bus_address >> INDEX_SHIFT) & IDX_MASK;
  assign req_ok   = req_idx < WORD_LIMIT;
  assign fill_cc  = ((in_data.bus_address >> TAG_SHIFT) << COND_TAG_SHIFT) |
                    (32'd1 << VALID_BIT);

  always_comb begin
    unique case (in_data.req_type) inside
      dmc_pkg::REQ_LOOKUP, dmc_pkg::REQ_FILL: in_waddr = in_idx[dmc_pkg::WORD_AW-1:0];
      default: in_waddr = in_data.bus_address[dmc_pkg::BYTE_AW-1:2];
    endcase
  end

  always_comb begin
    result = '0;
    unique case (req_r.req_type)
      dmc_pkg::REQ_RD_DATA: begin
        result.read_byte = dmc_pkg::in_window(req_r.bus_address, dmc_pkg::DATA_WIN_BASE) ?
                           dmc_pkg::get_lane(data_rdata, req_r.bus_address[1:0]) :
                           dmc_pkg::OUT_OF_WINDOW;
      end
      dmc_pkg::REQ_RD_CC: begin
        result.read_byte = dmc_pkg::in_window(req_r.bus_address, dmc_pkg::CC_WIN_BASE) ?
                           dmc_pkg::get_lane(cond_rdata, req_r.bus_address[1:0]) :
                           dmc_pkg::OUT_OF_WINDOW;
      end
      dmc_pkg::REQ_LOOKUP: begin
        if (present_r && req_ok && cond_rdata[VALID_BIT] &&
            ((cond_rdata >> COND_TAG_SHIFT) == (req_r.bus_address >> TAG_SHIFT))) begin
          result.hit      = 1'b1;
          result.hit_word = data_rdata;
        end
      end
      default: result = '0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dmc_pkg::ST_CLEAR: begin
        if (cnt_r == LAST_WORD) state_nxt = dmc_pkg::ST_IDLE;
      end
      dmc_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.req_type == dmc_pkg::REQ_INVAL) ? dmc_pkg::ST_INVAL :
                                                                 dmc_pkg::ST_RESP;
        end
      end
      dmc_pkg::ST_INVAL: begin
        if (cnt_r == LAST_WORD) state_nxt = dmc_pkg::ST_RESP;
      end
      dmc_pkg::ST_RESP: begin
        if (leave_resp) state_nxt = dmc_pkg::ST_IDLE;
      end
      default: state_nxt = dmc_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    in_stall      = 1'b1;
    cnt_nxt       = cnt_r;
    req_nxt       = req_r;
    data_req      = '0;
    cond_req      = '0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    present_nxt   = cfg_wr_en ? cfg_wr_data : present_r;
    unique case (state_r)
      dmc_pkg::ST_CLEAR: begin
        data_req.we   = 1'b1;
        data_req.addr = cnt_r;
        cond_req.we   = 1'b1;
        cond_req.addr = cnt_r;
        cnt_nxt       = cnt_r + 1'b1;
      end
      dmc_pkg::ST_IDLE: begin
        in_stall      = 1'b0;
        cnt_nxt       = '0;
        data_req.addr = in_waddr;
        cond_req.addr = in_waddr;
        if (accept) begin
          req_nxt     = in_data;
          data_req.re = 1'b1;
          cond_req.re = 1'b1;
          if (in_data.req_type == dmc_pkg::REQ_FILL && present_r && in_ok) begin
            data_req.we    = 1'b1;
            data_req.re    = 1'b0;
            data_req.wdata = in_data.write_value;
            cond_req.we    = 1'b1;
            cond_req.re    = 1'b0;
            cond_req.wdata = fill_cc;
          end
        end
      end
      dmc_pkg::ST_INVAL: begin
        cond_req.we   = 1'b1;
        cond_req.addr = cnt_r;
        cnt_nxt       = cnt_r + 1'b1;
      end
      dmc_pkg::ST_RESP: begin
        data_req.addr  = req_r.bus_address[dmc_pkg::BYTE_AW-1:2];
        cond_req.addr  = req_r.bus_address[dmc_pkg::BYTE_AW-1:2];
        data_req.wdata = dmc_pkg::put_lane(data_rdata, req_r.bus_address[1:0],
                                           req_r.write_value[7:0]);
        cond_req.wdata = dmc_pkg::put_lane(cond_rdata, req_r.bus_address[1:0],
                                           req_r.write_value[7:0]);
        if (leave_resp) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = result;
          data_req.we   = (req_r.req_type == dmc_pkg::REQ_WR_DATA) &&
                          dmc_pkg::in_window(req_r.bus_address, dmc_pkg::DATA_WIN_BASE);
          cond_req.we   = (req_r.req_type == dmc_pkg::REQ_WR_CC) &&
                          dmc_pkg::in_window(req_r.bus_address, dmc_pkg::CC_WIN_BASE);
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dmc_pkg::ST_CLEAR;
      cnt_r       <= '0;
      present_r   <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      present_r   <= present_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ rtl/direct_mapped_cache_ram.sv @@
// Top level of the direct-mapped cache RAM: sequencer plus data and condition-word memories.
//
// The data words and condition words each live in a 2048 x 32 single-port RAM with a
// registered read port, big-endian, so the byte at window offset 0 is bits 31:24 of
// word 0. Each request takes one beat in and gives one result beat. Byte reads, byte
// writes, lookups and fills address the RAM in the idle state, then form the result in
// the response state and, for byte writes, write the merged word back. Invalidate
// sweeps every condition word through the single RAM port. The response state
// stretches while the previous result beat is still held by out_stall. After reset
// the block runs a clearing pass over both RAMs, during which in_stall stays high;
// configuration writes are taken at any time.
module direct_mapped_cache_ram #(
  parameter int ENTRY_COUNT    = dmc_pkg::ENTRY_COUNT_DEF,
  parameter int INDEX_SHIFT    = dmc_pkg::INDEX_SHIFT_DEF,
  parameter int TAG_SHIFT      = dmc_pkg::TAG_SHIFT_DEF,
  parameter int COND_TAG_SHIFT = dmc_pkg::COND_TAG_SHIFT_DEF,
  parameter int VALID_BIT      = dmc_pkg::VALID_BIT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  dmc_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output dmc_pkg::out_beat_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  dmc_pkg::ram_req_t data_req;
  dmc_pkg::ram_req_t cond_req;
  logic [31:0]       data_rdata;
  logic [31:0]       cond_rdata;

  dmc_ctrl #(
    .ENTRY_COUNT    (ENTRY_COUNT),
    .INDEX_SHIFT    (INDEX_SHIFT),
    .TAG_SHIFT      (TAG_SHIFT),
    .COND_TAG_SHIFT (COND_TAG_SHIFT),
    .VALID_BIT      (VALID_BIT)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .data_req    (data_req),
    .data_rdata  (data_rdata),
    .cond_req    (cond_req),
    .cond_rdata  (cond_rdata)
  );

  dmc_ram #(
    .WIDTH (32),
    .DEPTH (dmc_pkg::STORE_WORDS)
  ) u_data_ram (
    .clk   (clk),
    .we    (data_req.we),
    .re    (data_req.re),
    .addr  (data_req.addr),
    .wdata (data_req.wdata),
    .rdata (data_rdata)
  );

  dmc_ram #(
    .WIDTH (32),
    .DEPTH (dmc_pkg::STORE_WORDS)
  ) u_cond_ram (
    .clk   (clk),
    .we    (cond_req.we),
    .re    (cond_req.re),
    .addr  (cond_req.addr),
    .wdata (cond_req.wdata),
    .rdata (cond_rdata)
  );

endmodule

@@ rtl/dmc_checker.sv @@
// Port-level checker for the direct-mapped cache RAM and its bind to the top level.
module dmc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input dmc_pkg::out_beat_t out_data
);

  a_stall_in_reset: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("Input taken right after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("Second beat taken while a request is in progress.");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> out_data.hit_word == 32'd0)
    else $error("Nonzero word on a miss.");

  a_hit_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hit |-> out_data.read_byte == 8'd0)
    else $error("Byte value reported with a hit.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("Stalled result beat changed.");

endmodule

bind direct_mapped_cache_ram dmc_checker u_dmc_checker (.*);
